// ===== src/mce_pkg.sv =====
// Shared types, constants and the micro-op program of the coefficient enumerator.
package mce_pkg;

  localparam int MOD_BITS_DEF = 31;
  localparam int FIELD_W      = 31;
  localparam int VALUE_W      = 32;
  localparam int MODE_W       = 2;
  localparam int PC_W         = 5;
  localparam logic [FIELD_W-1:0] PRIME_RESET = FIELD_W'(5);

  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADV    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HIGH   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [PC_W-1:0] PC_START     = 5'd0;
  localparam logic [PC_W-1:0] PC_START_END = 5'd1;
  localparam logic [PC_W-1:0] PC_ADV       = 5'd1;
  localparam logic [PC_W-1:0] PC_ADV_END   = 5'd6;
  localparam logic [PC_W-1:0] PC_HIGH      = 5'd6;
  localparam logic [PC_W-1:0] PC_HIGH_END  = 5'd27;

  typedef enum logic [0:0] {OP_MUL, OP_SUB} op_t;

  typedef enum logic [4:0] {
    S_B, S_A, S_A2, S_A3, S_A4, S_A5, S_T0, S_T1, S_BRES, S_ACNT, S_NEXT, S_VALUE,
    S_ONE, S_K5, S_K10, S_K15, S_K24, S_K40, S_K45
  } src_t;

  typedef enum logic [3:0] {
    D_B, D_A, D_A2, D_A3, D_A4, D_A5, D_T0, D_T1, D_BRES, D_C2, D_C3, D_C4, D_C5, D_C6
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t x;
    src_t y;
    dst_t d;
  } uop_t;

  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{OP_MUL, S_VALUE, S_ONE, D_BRES};
    case (pc)
      5'd0:  u = '{OP_MUL, S_VALUE, S_ONE, D_BRES};
      5'd1:  u = '{OP_MUL, S_BRES, S_ONE, D_B};
      5'd2:  u = '{OP_MUL, S_K5, S_B, D_T0};
      5'd3:  u = '{OP_MUL, S_K15, S_NEXT, D_T1};
      5'd4:  u = '{OP_SUB, S_T0, S_T1, D_T0};
      5'd5:  u = '{OP_MUL, S_NEXT, S_T0, D_C2};
      5'd6:  u = '{OP_MUL, S_ACNT, S_ONE, D_A};
      5'd7:  u = '{OP_MUL, S_BRES, S_ONE, D_B};
      5'd8:  u = '{OP_MUL, S_A, S_A, D_A2};
      5'd9:  u = '{OP_MUL, S_A2, S_A, D_A3};
      5'd10: u = '{OP_MUL, S_A2, S_A2, D_A4};
      5'd11: u = '{OP_MUL, S_A4, S_A, D_A5};
      5'd12: u = '{OP_MUL, S_K10, S_B, D_T0};
      5'd13: u = '{OP_MUL, S_K40, S_A, D_T1};
      5'd14: u = '{OP_SUB, S_T0, S_T1, D_T0};
      5'd15: u = '{OP_MUL, S_A2, S_T0, D_C3};
      5'd16: u = '{OP_MUL, S_K10, S_B, D_T0};
      5'd17: u = '{OP_MUL, S_K45, S_A, D_T1};
      5'd18: u = '{OP_SUB, S_T0, S_T1, D_T0};
      5'd19: u = '{OP_MUL, S_A3, S_T0, D_C4};
      5'd20: u = '{OP_MUL, S_K5, S_B, D_T0};
      5'd21: u = '{OP_MUL, S_K24, S_A, D_T1};
      5'd22: u = '{OP_SUB, S_T0, S_T1, D_T0};
      5'd23: u = '{OP_MUL, S_A4, S_T0, D_C5};
      5'd24: u = '{OP_MUL, S_K5, S_A, D_T1};
      5'd25: u = '{OP_SUB, S_B, S_T1, D_T0};
      5'd26: u = '{OP_MUL, S_A5, S_T0, D_C6};
      default: u = '{OP_MUL, S_VALUE, S_ONE, D_BRES};
    endcase
    return u;
  endfunction

endpackage

// ===== src/mce_if.sv =====
// Request channel interfaces: item in, result out, modulus write.
interface mce_item_if;
  logic                        valid;
  logic                        ready;
  logic [mce_pkg::MODE_W-1:0]  mode;
  logic [mce_pkg::VALUE_W-1:0] value;
  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface mce_res_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [mce_pkg::FIELD_W-1:0] a_now;
  logic [mce_pkg::FIELD_W-1:0] coef_two;
  logic [mce_pkg::FIELD_W-1:0] coef_three;
  logic [mce_pkg::FIELD_W-1:0] coef_four;
  logic [mce_pkg::FIELD_W-1:0] coef_five;
  logic [mce_pkg::FIELD_W-1:0] coef_six;
  modport source (output valid, ok, a_now, coef_two, coef_three, coef_four, coef_five,
                  coef_six, input ready);
  modport sink   (input valid, ok, a_now, coef_two, coef_three, coef_four, coef_five,
                  coef_six, output ready);
endinterface

interface mce_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mce_pkg::FIELD_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/mce_mulmod.sv =====
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
module mce_mulmod #(
  parameter int W = mce_pkg::MOD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mce_pkg::VALUE_W-1:0]  x,
  input  logic [W-1:0]                 y,
  input  logic [W-1:0]                 p,
  output logic                         done,
  output logic [W-1:0]                 res
);
  import mce_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] xs;
  logic [W-1:0]       ys;
  logic [W-1:0]       r;
  logic [W-1:0]       r_next;
  logic [W:0]         dbl;
  logic [W:0]         red1;
  logic [W:0]         sum;
  logic [W:0]         pw;

  always_comb begin
    pw   = {1'b0, p};
    dbl  = {r, 1'b0};
    red1 = (dbl >= pw) ? dbl - pw : dbl;
    sum  = red1 + (xs[VALUE_W-1] ? {1'b0, ys} : '0);
    r_next = (sum >= pw) ? W'(sum - pw) : W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        xs   <= x;
        ys   <= y;
        r    <= '0;
        cnt  <= CNT_W'(VALUE_W - 1);
      end else if (busy) begin
        r  <= r_next;
        xs <= xs << 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign res = r;

endmodule

// ===== src/mce_ctrl.sv =====
// Micro-op sequencer, operand registers and persistent enumeration state.
module mce_ctrl #(
  parameter int W = mce_pkg::MOD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [mce_pkg::MODE_W-1:0]  mode,
  input  logic [mce_pkg::VALUE_W-1:0] value,
  input  logic [W-1:0]                p,
  output logic                        idle,
  output logic                        fin,
  output logic                        ok,
  output logic [W-1:0]                a_now,
  output logic [W-1:0]                c2,
  output logic [W-1:0]                c3,
  output logic [W-1:0]                c4,
  output logic [W-1:0]                c5,
  output logic [W-1:0]                c6
);
  import mce_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_WAIT  = 3'b100
  } state_t;

  state_t             state;
  logic [MODE_W-1:0]  mode_q;
  logic [VALUE_W-1:0] value_q;
  logic [PC_W-1:0]    pc;
  logic [PC_W-1:0]    pc_end;
  logic [W-1:0]       rb, ra, ra2, ra3, ra4, ra5, t0, t1, bres, acnt;
  logic [W:0]         nxt;
  logic [W-1:0]       one_y;
  uop_t               u;
  logic [VALUE_W-1:0] xv;
  logic [VALUE_W-1:0] yv;
  logic [W-1:0]       yw;
  logic [W-1:0]       sub_res;
  logic               mul_start;
  logic               mul_done;
  logic [W-1:0]       mul_res;
  logic               wr_en;
  logic [W-1:0]       wr_data;

  function automatic logic [VALUE_W-1:0] pick(input src_t s, input logic [VALUE_W-1:0] v,
      input logic [W-1:0] b, a, a2, a3, a4, a5, x0, x1, br, ac, nx);
    logic [VALUE_W-1:0] o;
    o = '0;
    case (s)
      S_B:     o = VALUE_W'(b);
      S_A:     o = VALUE_W'(a);
      S_A2:    o = VALUE_W'(a2);
      S_A3:    o = VALUE_W'(a3);
      S_A4:    o = VALUE_W'(a4);
      S_A5:    o = VALUE_W'(a5);
      S_T0:    o = VALUE_W'(x0);
      S_T1:    o = VALUE_W'(x1);
      S_BRES:  o = VALUE_W'(br);
      S_ACNT:  o = VALUE_W'(ac);
      S_NEXT:  o = VALUE_W'(nx);
      S_VALUE: o = v;
      S_ONE:   o = VALUE_W'(1);
      S_K5:    o = VALUE_W'(5);
      S_K10:   o = VALUE_W'(10);
      S_K15:   o = VALUE_W'(15);
      S_K24:   o = VALUE_W'(24);
      S_K40:   o = VALUE_W'(40);
      S_K45:   o = VALUE_W'(45);
      default: o = '0;
    endcase
    return o;
  endfunction

  always_comb begin
    nxt   = {1'b0, acnt} + 1'b1;
    one_y = (p == W'(1)) ? '0 : W'(1);
    u     = prog(pc);
    xv    = pick(u.x, value_q, rb, ra, ra2, ra3, ra4, ra5, t0, t1, bres, acnt, nxt[W-1:0]);
    yv    = pick(u.y, value_q, rb, ra, ra2, ra3, ra4, ra5, t0, t1, bres, acnt, nxt[W-1:0]);
    yw    = (u.y == S_ONE) ? one_y : yv[W-1:0];
    // both operands below p, so W-bit wrap gives the residue
    sub_res   = xv[W-1:0] - yw + ((xv[W-1:0] < yw) ? p : '0);
    mul_start = (state == ST_ISSUE) && (u.op == OP_MUL);
    wr_en     = ((state == ST_ISSUE) && (u.op == OP_SUB)) || ((state == ST_WAIT) && mul_done);
    wr_data   = (state == ST_ISSUE) ? sub_res : mul_res;
  end

  mce_mulmod #(.W(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (xv),
    .y     (yw),
    .p     (p),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fin   <= 1'b0;
      ok    <= 1'b0;
      bres  <= '0;
      acnt  <= '0;
      c2    <= '0;
      c3    <= '0;
      c4    <= '0;
      c5    <= '0;
      c6    <= '0;
    end else begin
      fin <= 1'b0;
      if (wr_en) begin
        case (u.d)
          D_B:     rb   <= wr_data;
          D_A:     ra   <= wr_data;
          D_A2:    ra2  <= wr_data;
          D_A3:    ra3  <= wr_data;
          D_A4:    ra4  <= wr_data;
          D_A5:    ra5  <= wr_data;
          D_T0:    t0   <= wr_data;
          D_T1:    t1   <= wr_data;
          D_BRES:  bres <= wr_data;
          D_C2:    c2   <= wr_data;
          D_C3:    c3   <= wr_data;
          D_C4:    c4   <= wr_data;
          D_C5:    c5   <= wr_data;
          D_C6:    c6   <= wr_data;
          default: t1   <= wr_data;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (go) begin
            mode_q  <= mode;
            value_q <= value;
            ok      <= 1'b1;
            case (mode)
              MODE_START: begin
                pc     <= PC_START;
                pc_end <= PC_START_END;
                state  <= ST_ISSUE;
              end
              MODE_ADV: begin
                if (nxt >= {1'b0, p}) begin
                  acnt <= p;
                  ok   <= 1'b0;
                  fin  <= 1'b1;
                end else begin
                  pc     <= PC_ADV;
                  pc_end <= PC_ADV_END;
                  state  <= ST_ISSUE;
                end
              end
              MODE_HIGH: begin
                pc     <= PC_HIGH;
                pc_end <= PC_HIGH_END;
                state  <= ST_ISSUE;
              end
              default: begin
                ok  <= 1'b0;
                fin <= 1'b1;
              end
            endcase
          end
        end
        ST_ISSUE: begin
          if (u.op == OP_MUL) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: ;
        default: state <= ST_IDLE;
      endcase
      if (wr_en) begin
        if (pc + 1'b1 == pc_end) begin
          if (mode_q == MODE_START) begin
            acnt <= '0;
            c2   <= '0;
          end else if (mode_q == MODE_ADV) begin
            acnt <= nxt[W-1:0];
          end
          fin   <= 1'b1;
          state <= ST_IDLE;
        end else begin
          pc    <= pc + 1'b1;
          state <= ST_ISSUE;
        end
      end
    end
  end

  assign idle  = (state == ST_IDLE);
  assign a_now = acnt;

endmodule

// ===== src/mod_p_coefficient_enumerator_core.sv =====
// Top level: request channels, modulus register and result register.
// One request is taken at a time; it is accepted when the sequencer is idle and the
// previous result has been taken. Every request gives one result. Each modular product
// goes through a bit-serial multiplier (issue, 32 multiplier bits and write-back); a
// subtract is written at issue. A start request runs one product, an advance four
// products and a subtract, a higher-coefficient request 17 products and four
// subtracts; an advance past the end or an unused mode gives its result with no product.
// The modulus register is 31 bits, resets to 5, and a value of 0 acts as 1.
module mod_p_coefficient_enumerator_core #(
  parameter int MOD_BITS = mce_pkg::MOD_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  mce_item_if.sink     item,
  mce_res_if.source    result,
  mce_cfg_if.sink      cfg
);
  import mce_pkg::*;

  logic [MOD_BITS-1:0] prime;
  logic [MOD_BITS-1:0] p_eff;
  logic                go;
  logic                idle;
  logic                fin;
  logic                ok_c;
  logic [MOD_BITS-1:0] a_c, c2, c3, c4, c5, c6;
  logic                res_valid;

  assign p_eff      = (prime == '0) ? MOD_BITS'(1) : prime;
  assign item.ready = idle && !res_valid && !fin;
  assign go         = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= PRIME_RESET[MOD_BITS-1:0];
    end else if (cfg.valid) begin
      prime <= cfg.data[MOD_BITS-1:0];
    end
  end

  mce_ctrl #(.W(MOD_BITS)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .mode  (item.mode),
    .value (item.value),
    .p     (p_eff),
    .idle  (idle),
    .fin   (fin),
    .ok    (ok_c),
    .a_now (a_c),
    .c2    (c2),
    .c3    (c3),
    .c4    (c4),
    .c5    (c5),
    .c6    (c6)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      if (fin) begin
        res_valid         <= 1'b1;
        result.ok         <= ok_c;
        result.a_now      <= FIELD_W'(a_c);
        result.coef_two   <= FIELD_W'(c2);
        result.coef_three <= FIELD_W'(c3);
        result.coef_four  <= FIELD_W'(c4);
        result.coef_five  <= FIELD_W'(c5);
        result.coef_six   <= FIELD_W'(c6);
      end
    end
  end

  assign result.valid = res_valid;

endmodule

// ===== src/mce_checker.sv =====
// Port-level checks for the coefficient enumerator, bound to the top level.
module mce_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mce_pkg::FIELD_W-1:0] out_a_now
);
  import mce_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in work");

  a_no_take_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before taken");

  a_payload_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_a_now))
    else $error("result payload changed while stalled");

endmodule

bind mod_p_coefficient_enumerator_core mce_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_a_now (result.a_now)
);

// ===== bench/tb_top.sv =====
// Testbench for the mod-p coefficient enumerator: directed table, then random requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mce_pkg::*;

  localparam int N_RANDOM = 1500;
  localparam longint unsigned MOD_MASK = (64'd1 << MOD_BITS_DEF) - 1;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic ok;
    logic [FIELD_W-1:0] a_now, c2, c3, c4, c5, c6;
  } coef_res_t;

  typedef struct {
    bit                  is_cfg;
    logic [MODE_W-1:0]   mode;
    logic [VALUE_W-1:0]  value;
    bit                  typed;
    logic                ok;
    logic [FIELD_W-1:0]  a_now;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  mce_item_if item ();
  mce_res_if  result ();
  mce_cfg_if  cfg ();

  mod_p_coefficient_enumerator_core u_top (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source), .cfg(cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // enumerator state as the bench sees it
  longint unsigned modulus_reg = 5;
  longint unsigned b_res, a_cnt, c2_r, c3_r, c4_r, c5_r, c6_r;
  coef_res_t coef_q[$];
  int fails = 0;
  int n_results = 0;
  int n_items = 0;
  int n_cfg = 0;
  int src_idle_pct = 37;
  int snk_idle_pct = 82;
  int cycles = 0;

  function automatic longint unsigned lin_res(longint unsigned kb, longint unsigned b,
                                              longint unsigned ka, longint unsigned a,
                                              longint unsigned p);
    longint unsigned pos, neg;
    pos = ((kb % p) * b) % p;
    neg = ((ka % p) * a) % p;
    return (pos + (p - neg)) % p;
  endfunction

  function automatic coef_res_t enumerate_step(logic [MODE_W-1:0] mode,
                                               logic [VALUE_W-1:0] value);
    longint unsigned p, nxt, a, b, a2, a3, a4, a5;
    coef_res_t r;
    logic okv;
    p = modulus_reg & MOD_MASK;
    if (p == 0) p = 1;
    okv = 1'b1;
    if (mode == MODE_START) begin
      b_res = longint'(value) % p;
      a_cnt = 0;
      c2_r = 0;
    end else if (mode == MODE_ADV) begin
      nxt = (a_cnt & MOD_MASK) + 1;
      if (nxt >= p) begin
        a_cnt = p & MOD_MASK;
        okv = 1'b0;
      end else begin
        b = b_res % p;
        a_cnt = nxt;
        c2_r = (nxt * lin_res(5, b, 15, nxt, p)) % p;
      end
    end else if (mode == MODE_HIGH) begin
      a = a_cnt % p;
      b = b_res % p;
      a2 = (a * a) % p;
      a3 = (a2 * a) % p;
      a4 = (a2 * a2) % p;
      a5 = (a4 * a) % p;
      c3_r = (a2 * lin_res(10, b, 40, a, p)) % p;
      c4_r = (a3 * lin_res(10, b, 45, a, p)) % p;
      c5_r = (a4 * lin_res(5, b, 24, a, p)) % p;
      c6_r = (a5 * lin_res(1, b, 5, a, p)) % p;
    end else begin
      okv = 1'b0;
    end
    r.ok = okv;
    r.a_now = a_cnt[FIELD_W-1:0];
    r.c2 = c2_r[FIELD_W-1:0];
    r.c3 = c3_r[FIELD_W-1:0];
    r.c4 = c4_r[FIELD_W-1:0];
    r.c5 = c5_r[FIELD_W-1:0];
    r.c6 = c6_r[FIELD_W-1:0];
    return r;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    fails++;
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding", cycles, coef_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: stall at random, check each accepted result
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      result.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    coef_res_t want;
    if (!rst && result.valid && result.ready) begin
      n_results++;
      if (coef_q.size() == 0) begin
        report("results outstanding", 1, 0);
      end else begin
        want = coef_q.pop_front();
        if (result.ok !== want.ok) report("ok", result.ok, want.ok);
        if (result.a_now !== want.a_now) report("a_now", result.a_now, want.a_now);
        if (result.coef_two !== want.c2) report("coef_two", result.coef_two, want.c2);
        if (result.coef_three !== want.c3) report("coef_three", result.coef_three, want.c3);
        if (result.coef_four !== want.c4) report("coef_four", result.coef_four, want.c4);
        if (result.coef_five !== want.c5) report("coef_five", result.coef_five, want.c5);
        if (result.coef_six !== want.c6) report("coef_six", result.coef_six, want.c6);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic drain();
    item.valid = 1'b0;
    while (coef_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_modulus(logic [FIELD_W-1:0] data);
    drain();
    cfg.valid = 1'b1;
    cfg.data = data;
    do @(posedge clk); while (!cfg.ready);
    modulus_reg = longint'(data) & MOD_MASK;
    n_cfg++;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic send_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                              output coef_res_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      item.valid = 1'b0;
      @(negedge clk);
    end
    item.valid = 1'b1;
    item.mode = mode;
    item.value = value;
    do @(posedge clk); while (!item.ready);
    want = enumerate_step(mode, value);
    coef_q.push_back(want);
    n_items++;
    @(negedge clk);
  endtask

  stim_row_t rows[$];
  logic [FIELD_W-1:0] moduli[6] = '{31'd13, 31'h7FFFFFFF, 31'd5, 31'd0, 31'd65521, 31'd7};

  initial begin
    coef_res_t want;
    logic [MODE_W-1:0] m;
    logic [VALUE_W-1:0] v;
    int pick;
    item.valid = 1'b0;
    item.mode = MODE_START;
    item.value = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    rows = '{
      '{0, MODE_UNUSED, 32'd0,         1, 1'b0, 31'd0},
      '{0, MODE_HIGH,   32'd0,         1, 1'b1, 31'd0},
      '{0, MODE_START,  32'hFFFFFFFF,  1, 1'b1, 31'd0},
      '{0, MODE_ADV,    32'd0,         1, 1'b1, 31'd1},
      '{0, MODE_HIGH,   32'd0,         0, 1'b1, 31'd0},
      '{0, MODE_ADV,    32'hFFFFFFFF,  1, 1'b1, 31'd2},
      '{0, MODE_ADV,    32'd0,         1, 1'b1, 31'd3},
      '{0, MODE_ADV,    32'd0,         1, 1'b1, 31'd4},
      '{0, MODE_ADV,    32'd0,         1, 1'b0, 31'd5},
      '{0, MODE_ADV,    32'd0,         1, 1'b0, 31'd5},
      '{0, MODE_HIGH,   32'd0,         0, 1'b1, 31'd0},
      '{0, MODE_START,  32'd0,         1, 1'b1, 31'd0},
      '{0, MODE_ADV,    32'd0,         1, 1'b1, 31'd1},
      '{0, MODE_HIGH,   32'd0,         0, 1'b1, 31'd0},
      '{1, MODE_START,  32'd0,         0, 1'b1, 31'd0},
      '{0, MODE_ADV,    32'd0,         1, 1'b0, 31'd1},
      '{0, MODE_HIGH,   32'd0,         0, 1'b1, 31'd0},
      '{0, MODE_START,  32'hFFFFFFFF,  1, 1'b1, 31'd0},
      '{1, MODE_START,  32'h7FFFFFFF,  0, 1'b1, 31'd0},
      '{0, MODE_START,  32'hFFFFFFFF,  1, 1'b1, 31'd0},
      '{0, MODE_ADV,    32'd0,         1, 1'b1, 31'd1},
      '{0, MODE_HIGH,   32'd0,         0, 1'b1, 31'd0},
      '{1, MODE_START,  32'd7,         0, 1'b1, 31'd0},
      '{0, MODE_HIGH,   32'd0,         0, 1'b1, 31'd0},
      '{0, MODE_ADV,    32'h5A5A5A5A,  0, 1'b1, 31'd0},
      '{0, MODE_UNUSED, 32'hA5A5A5A5,  0, 1'b0, 31'd0}
    };
    b_res = 0; a_cnt = 0; c2_r = 0; c3_r = 0; c4_r = 0; c5_r = 0; c6_r = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_modulus(rows[i].value[FIELD_W-1:0]);
      end else begin
        send_request(rows[i].mode, rows[i].value, want);
        if (rows[i].typed) begin
          if (want.ok !== rows[i].ok)
            report($sformatf("table row %0d ok", i), want.ok, rows[i].ok);
          if (want.a_now !== rows[i].a_now)
            report($sformatf("table row %0d a_now", i), want.a_now, rows[i].a_now);
        end
      end
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        src_idle_pct = 82;
        snk_idle_pct = 37;
      end else if (i == 2 * N_RANDOM / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (i % 250 == 0) begin
        // modulus changes without a fresh start, so stale a and b are reduced
        if (i / 250 == 5) write_modulus(31'($urandom_range(32'h7FFFFFFF, 5)));
        else write_modulus(moduli[i / 250]);
      end
      if (i == 700) drain();
      pick = $urandom_range(99);
      v = $urandom();
      if (pick < 12) m = MODE_START;
      else if (pick < 72) m = MODE_ADV;
      else if (pick < 95) m = MODE_HIGH;
      else m = MODE_UNUSED;
      send_request(m, v, want);
    end
    item.valid = 1'b0;

    while (coef_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("%0d requests sent and %0d results checked over %0d modulus writes,",
             n_items, n_results, n_cfg);
    $display("covering starts, advances to the end, higher terms and the unused mode");
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fails);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
